@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes, status codes and the side-band record that travels
// along the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_EQ       = 4'd4,
        FN_LT       = 4'd5,
        FN_GT       = 4'd6,
        FN_LE       = 4'd7,
        FN_GE       = 4'd8,
        FN_NE       = 4'd9,
        FN_MIN      = 4'd10,
        FN_MAX      = 4'd11,
        FN_INC      = 4'd12,
        FN_DEC      = 4'd13,
        FN_TO_INT   = 4'd14,
        FN_FROM_INT = 4'd15
    } t_func;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    // value is always held sign-extended to the 32-bit result field
    typedef struct packed {
        t_func       func;
        logic [31:0] value;
        logic        flag;
        logic [1:0]  status;
        logic        neg;
        logic        div0;
    } t_side;

endpackage

@@ rtl/fpa_mul.sv @@
// ----------------------------------------------------------------------------
// fpa_mul
// Two-stage magnitude multiplier: product, then round half away from zero,
// drop the fraction bits, apply the sign and saturate.
// ----------------------------------------------------------------------------
module fpa_mul #(
    parameter int EFF_BITS  = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [EFF_BITS-1:0]        i_mag_a,
    input  logic [EFF_BITS-1:0]        i_mag_b,
    input  logic                       i_neg,
    output logic signed [EFF_BITS-1:0] o_value,
    output logic                       o_ovf
);

    localparam int PW = 2 * EFF_BITS;
    localparam logic [PW-1:0] HALF   = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] LIM_P  = (PW'(1) << (EFF_BITS - 1)) - PW'(1);
    localparam logic [PW-1:0] LIM_N  = PW'(1) << (EFF_BITS - 1);
    localparam logic [EFF_BITS-1:0] WMAX = {1'b0, {(EFF_BITS-1){1'b1}}};
    localparam logic [EFF_BITS-1:0] WMIN = {1'b1, {(EFF_BITS-1){1'b0}}};

    logic [PW-1:0]       r_prod;
    logic                r_neg;
    logic [PW-1:0]       w_rnd;
    logic                w_ovf;
    logic [EFF_BITS-1:0] n_value;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= PW'(i_mag_a) * PW'(i_mag_b);
            r_neg   <= i_neg;
            o_value <= n_value;
            o_ovf   <= w_ovf;
        end
    end

    always_comb begin
        w_rnd = (r_prod + HALF) >> FRAC_BITS;
        w_ovf = r_neg ? (w_rnd > LIM_N) : (w_rnd > LIM_P);
        if (w_ovf) begin
            n_value = r_neg ? WMIN : WMAX;
        end else if (r_neg) begin
            n_value = EFF_BITS'(0) - w_rnd[EFF_BITS-1:0];
        end else begin
            n_value = w_rnd[EFF_BITS-1:0];
        end
    end

endmodule

@@ rtl/fpa_div.sv @@
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage. An entry stage
// flags quotients that cannot fit in EFF_BITS bits.
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int EFF_BITS  = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [EFF_BITS+FRAC_BITS-1:0] i_num,
    input  logic [EFF_BITS-1:0]           i_den,
    output logic [EFF_BITS-1:0]           o_quo,
    output logic [EFF_BITS-1:0]           o_rem,
    output logic [EFF_BITS-1:0]           o_den,
    output logic                          o_ovf
);

    localparam int NW = EFF_BITS + FRAC_BITS;
    localparam int QB = EFF_BITS;
    localparam int CW = ((FRAC_BITS > EFF_BITS) ? FRAC_BITS : EFF_BITS) + 1;

    logic [EFF_BITS-1:0] r_rem [0:QB];
    logic [EFF_BITS-1:0] r_quo [0:QB];
    logic [EFF_BITS-1:0] r_num [0:QB];
    logic [EFF_BITS-1:0] r_den [0:QB];
    logic                r_ovf [0:QB];

    logic [CW-1:0] w_hi;

    assign w_hi = CW'(i_num[NW-1:EFF_BITS]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_hi[EFF_BITS-1:0];
            r_quo[0] <= '0;
            r_num[0] <= i_num[EFF_BITS-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= (w_hi >= CW'(i_den));
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [EFF_BITS:0] w_trial;
        logic              w_ge;

        assign w_trial = {r_rem[k], r_num[k][EFF_BITS-1-k]};
        assign w_ge    = w_trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? EFF_BITS'(w_trial - {1'b0, r_den[k]})
                                   : w_trial[EFF_BITS-1:0];
                r_quo[k+1] <= {r_quo[k][EFF_BITS-2:0], w_ge};
                r_num[k+1] <= r_num[k];
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_quo[QB];
    assign o_rem = r_rem[QB];
    assign o_den = r_den[QB];
    assign o_ovf = r_ovf[QB];

endmodule

@@ rtl/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed fixed-point ALU with FRAC_BITS fraction bits: add, sub, mul, div,
// compares, min/max, inc/dec and integer conversions, saturating.
// ----------------------------------------------------------------------------
// One transfer in per clock when the output side keeps up. Every operation
// goes through the same registers: input, stage 2, the side pipeline aligned
// with the pipelined divider, which retires one quotient bit per stage, then output.
// The whole pipeline advances when the output register is empty or being
// taken, so results leave in the order the operations came in.
module fixed_point_alu #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // func[3:0], operand_a[35:4], operand_b[67:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // value[31:0], flag[32], status[34:33]
);

    localparam int E  = (WORD_BITS > 32) ? 32 : WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int QB = E;
    localparam logic signed [E-1:0] WMAX = {1'b0, {(E-1){1'b1}}};
    localparam logic signed [E-1:0] WMIN = {1'b1, {(E-1){1'b0}}};
    localparam logic [E:0] LIM_P = {2'b00, {(E-1){1'b1}}};
    localparam logic [E:0] LIM_N = {2'b01, {(E-1){1'b0}}};

    logic w_en;

    // stage 1: input register
    logic                 r1_vld;
    fpa_pkg::t_func       r1_func;
    logic signed [E-1:0]  r1_a;
    logic signed [E-1:0]  r1_b;

    // stage 2: simple ops resolved, operands prepared
    logic                 r2_vld;
    fpa_pkg::t_side       r2_side;
    logic [E-1:0]         r2_ma;
    logic [E-1:0]         r2_mb;
    logic [E+F-1:0]       r2_num;

    fpa_pkg::t_side       n2_side;
    logic [E-1:0]         w_ma;
    logic [E-1:0]         w_mb;
    logic signed [E:0]    w_sum;
    logic signed [E+F-1:0] w_fi;
    logic signed [E-1:0]  w_res;

    // side pipeline aligned with the divider
    fpa_pkg::t_side       r_side [0:QB];
    logic                 r_vld  [0:QB];

    logic signed [E-1:0]  w_mul_value;
    logic                 w_mul_ovf;
    logic [E-1:0]         w_quo;
    logic [E-1:0]         w_rem;
    logic [E-1:0]         w_den;
    logic                 w_dovf;

    // output stage
    logic                 r_out_vld;
    logic [39:0]          r_out_data;
    fpa_pkg::t_side       w_fin;
    logic [E:0]           w_m;
    logic                 w_rnd;
    logic                 w_qovf;
    logic signed [E-1:0]  w_dval;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld    <= s_axis_tvalid;
            r2_vld    <= r1_vld;
            r_out_vld <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_func    <= fpa_pkg::t_func'(s_axis_tdata[3:0]);
            r1_a       <= s_axis_tdata[4 +: E];
            r1_b       <= s_axis_tdata[36 +: E];
            r2_side    <= n2_side;
            r2_ma      <= w_ma;
            r2_mb      <= w_mb;
            r2_num     <= {w_ma, {F{1'b0}}};
            r_out_data <= {5'b0, w_fin.status, w_fin.flag, w_fin.value};
        end
    end

    // stage 2 logic
    always_comb begin
        w_ma  = r1_a[E-1] ? E'(E'(0) - r1_a) : r1_a;
        w_mb  = r1_b[E-1] ? E'(E'(0) - r1_b) : r1_b;
        w_sum = '0;
        w_fi  = {{F{r1_a[E-1]}}, r1_a} <<< F;
        w_res = '0;
        n2_side        = '0;
        n2_side.func   = r1_func;
        n2_side.status = fpa_pkg::ST_OK;
        n2_side.neg    = r1_a[E-1] ^ r1_b[E-1];
        n2_side.div0   = (r1_b == '0);
        case (r1_func)
            fpa_pkg::FN_ADD, fpa_pkg::FN_SUB, fpa_pkg::FN_INC, fpa_pkg::FN_DEC: begin
                case (r1_func)
                    fpa_pkg::FN_ADD: w_sum = {r1_a[E-1], r1_a} + {r1_b[E-1], r1_b};
                    fpa_pkg::FN_SUB: w_sum = {r1_a[E-1], r1_a} - {r1_b[E-1], r1_b};
                    fpa_pkg::FN_INC: w_sum = {r1_a[E-1], r1_a} + (E+1)'(1);
                    default:         w_sum = {r1_a[E-1], r1_a} - (E+1)'(1);
                endcase
                if (w_sum[E] != w_sum[E-1]) begin
                    w_res          = w_sum[E] ? WMIN : WMAX;
                    n2_side.status = fpa_pkg::ST_OVF;
                end else begin
                    w_res = w_sum[E-1:0];
                end
            end
            fpa_pkg::FN_EQ: n2_side.flag = (r1_a == r1_b);
            fpa_pkg::FN_LT: n2_side.flag = (r1_a <  r1_b);
            fpa_pkg::FN_GT: n2_side.flag = (r1_a >  r1_b);
            fpa_pkg::FN_LE: n2_side.flag = (r1_a <= r1_b);
            fpa_pkg::FN_GE: n2_side.flag = (r1_a >= r1_b);
            fpa_pkg::FN_NE: n2_side.flag = (r1_a != r1_b);
            fpa_pkg::FN_MIN: w_res = (r1_a < r1_b) ? r1_a : r1_b;
            fpa_pkg::FN_MAX: w_res = (r1_a > r1_b) ? r1_a : r1_b;
            fpa_pkg::FN_TO_INT: w_res = r1_a >>> F;
            fpa_pkg::FN_FROM_INT: begin
                // in range only when the bits above the sign all match it
                if (&w_fi[E+F-1:E-1] || !(|w_fi[E+F-1:E-1])) begin
                    w_res = w_fi[E-1:0];
                end else begin
                    w_res          = w_fi[E+F-1] ? WMIN : WMAX;
                    n2_side.status = fpa_pkg::ST_OVF;
                end
            end
            default: w_res = '0;   // mul and div finish further down
        endcase
        n2_side.value = 32'(w_res);
    end

    fpa_mul #(
        .EFF_BITS  (E),
        .FRAC_BITS (F)
    ) u_mul (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_mag_a (r2_ma),
        .i_mag_b (r2_mb),
        .i_neg   (r2_side.neg),
        .o_value (w_mul_value),
        .o_ovf   (w_mul_ovf)
    );

    fpa_div #(
        .EFF_BITS  (E),
        .FRAC_BITS (F)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_num),
        .i_den (r2_mb),
        .o_quo (w_quo),
        .o_rem (w_rem),
        .o_den (w_den),
        .o_ovf (w_dovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r2_side;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_side
        fpa_pkg::t_side w_next;

        always_comb begin
            w_next = r_side[k];
            // multiplier result is ready alongside side stage 1
            if (k == 1 && r_side[k].func == fpa_pkg::FN_MUL) begin
                w_next.value  = 32'(w_mul_value);
                w_next.status = w_mul_ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side[k+1] <= w_next;
            end
        end
    end

    // divide finish: round half away from zero, sign, saturate; a zero divisor gives ST_DIV0
    always_comb begin
        w_rnd  = {w_rem, 1'b0} >= {1'b0, w_den};
        w_m    = {1'b0, w_quo} + (E+1)'(w_rnd);
        w_qovf = w_dovf || (r_side[QB].neg ? (w_m > LIM_N) : (w_m > LIM_P));
        if (w_qovf) begin
            w_dval = r_side[QB].neg ? WMIN : WMAX;
        end else if (r_side[QB].neg) begin
            w_dval = E'(E'(0) - w_m[E-1:0]);
        end else begin
            w_dval = w_m[E-1:0];
        end
        w_fin = r_side[QB];
        if (r_side[QB].func == fpa_pkg::FN_DIV) begin
            if (r_side[QB].div0) begin
                w_fin.value  = '0;
                w_fin.status = fpa_pkg::ST_DIV0;
            end else begin
                w_fin.value  = 32'(w_dval);
                w_fin.status = w_qovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
            end
        end
    end

endmodule
